### hdl/sgb_pkg.sv
`default_nettype none
package sgb_pkg;

   localparam int MAX_RADIUS_DEF = 7;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;

   localparam int CH_N        = 4;
   localparam int CH_W        = 8;
   localparam int PIX_W       = CH_N * CH_W;
   localparam int WEIGHTS_W   = 64;
   localparam int RADIUS_W    = 3;
   localparam int DIM_W       = 11;
   localparam int OUT_POS_W   = 10;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int QUOT_BITS   = 8;

   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 3'd0;
   localparam logic [DIM_W-1:0]    WIDTH_RESET  = 11'd1024;
   localparam logic [DIM_W-1:0]    HEIGHT_RESET = 11'd1024;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIUS  = 2'd0,
      CSR_WEIGHTS = 2'd1,
      CSR_WIDTH   = 2'd2,
      CSR_HEIGHT  = 2'd3
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_HSET,
      ST_HTAP,
      ST_HDIVGO,
      ST_HDIVW,
      ST_HWR,
      ST_HRAW,
      ST_VCHK,
      ST_VSET,
      ST_VADR,
      ST_VACC,
      ST_VDIVGO,
      ST_VDIVW,
      ST_VRAWA,
      ST_VRAWD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic h_setup;
      logic h_tap;
      logic h_raw;
      logic h_write;
      logic v_setup;
      logic v_addr;
      logic v_acc;
      logic v_raw_addr;
      logic div_start;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic drop;
      logic has_h;
      logic r_zero;
      logic h_tap_last;
      logic h_last_x;
      logic emit_pend;
      logic v_last;
      logic div_done;
      logic out_free;
   } status_type;

   function automatic logic [CH_W-1:0] weight_of(input logic [WEIGHTS_W-1:0] w,
                                                 input logic [2:0] d);
      return w[8*d +: 8];
   endfunction

endpackage
`default_nettype wire

### hdl/sgb_if.sv
`default_nettype none
interface sgb_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [31:0] pixel_word;
   modport source (output valid, func, pixel_word, input ready);
   modport sink (input valid, func, pixel_word, output ready);
endinterface

interface sgb_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] blurred_pixel;
   logic [9:0]  out_column;
   logic [9:0]  out_row;
   logic        frame_end;
   modport source (output valid, blurred_pixel, out_column, out_row, frame_end, input ready);
   modport sink (input valid, blurred_pixel, out_column, out_row, frame_end, output ready);
endinterface

interface sgb_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hdl/sgb_div.sv
`default_nettype none
module sgb_div #(
   parameter int SUM_W  = 20,
   parameter int AREA_W = 12
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   input  wire logic [sgb_pkg::CH_N-1:0][SUM_W-1:0]     sums,
   input  wire logic [AREA_W-1:0]                       area,
   output logic                                         done,
   output logic [sgb_pkg::CH_N-1:0][sgb_pkg::CH_W-1:0]  quot
);

   localparam int CNT_W = $clog2(sgb_pkg::QUOT_BITS);

   logic                                        busy_ff, busy_in;
   logic                                        done_ff, done_in;
   logic [CNT_W-1:0]                            cnt_ff, cnt_in;
   logic [sgb_pkg::CH_N-1:0][SUM_W-1:0]         rem_ff, rem_in;
   logic [sgb_pkg::CH_N-1:0][sgb_pkg::CH_W-1:0] q_ff, q_in;
   logic [SUM_W-1:0]                            shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      shifted = SUM_W'(area) << cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(sgb_pkg::QUOT_BITS - 1);
         rem_in  = sums;
         q_in    = '0;
      end else if (busy_ff) begin
         for (int ch = 0; ch < sgb_pkg::CH_N; ch++) begin
            if (rem_ff[ch] >= shifted) begin
               rem_in[ch]     = rem_ff[ch] - shifted;
               q_in[ch][cnt_ff] = 1'b1;
            end
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = (area == '0) ? '0 : q_ff;

endmodule
`default_nettype wire

### hdl/sgb_datapath.sv
`default_nettype none
module sgb_datapath #(
   parameter int MAX_RADIUS = sgb_pkg::MAX_RADIUS_DEF,
   parameter int MAX_WIDTH  = sgb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = sgb_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_func,
   input  wire logic [sgb_pkg::PIX_W-1:0]         req_pixel,
   input  wire logic                              csr_we,
   input  wire logic [sgb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [sgb_pkg::CSR_DATA_W-1:0]    csr_data,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_valid,
   output logic [sgb_pkg::PIX_W-1:0]              rsp_pixel,
   output logic [sgb_pkg::OUT_POS_W-1:0]          rsp_column,
   output logic [sgb_pkg::OUT_POS_W-1:0]          rsp_row,
   output logic                                   rsp_frame_end,
   input  wire sgb_pkg::cmd_type                  cmd,
   output sgb_pkg::status_type                    status
);

   localparam int WIN_LEN   = 2 * MAX_RADIUS + 1;
   localparam int LINE_ROWS = 2 * MAX_RADIUS + 2;
   localparam int RW        = $clog2(MAX_RADIUS + 1);
   localparam int KW        = RW + 1;
   localparam int WIW       = $clog2(WIN_LEN);
   localparam int SW        = $clog2(LINE_ROWS);
   localparam int XW        = $clog2(MAX_WIDTH);
   localparam int YW        = $clog2(MAX_HEIGHT);
   localparam int CW        = $clog2(MAX_WIDTH + 1);
   localparam int HW        = $clog2(MAX_HEIGHT + 1);
   localparam int IRW       = $clog2(MAX_HEIGHT + 2 * MAX_RADIUS + 2);
   localparam int NW        = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH
                                     + MAX_RADIUS + 1);
   localparam int SUM_W     = 2 * sgb_pkg::CH_W + $clog2(WIN_LEN);
   localparam int AREA_W    = sgb_pkg::CH_W + $clog2(WIN_LEN);
   localparam int CXW       = XW + 2;
   localparam int RYW       = YW + 2;
   localparam int MAW       = SW + XW;
   localparam int MEM_DEPTH = LINE_ROWS * (1 << XW);

   localparam int CH_N = sgb_pkg::CH_N;
   localparam int CH_W = sgb_pkg::CH_W;
   localparam int PIX_W = sgb_pkg::PIX_W;
   localparam int PROD_W = 2 * sgb_pkg::CH_W;

   // configuration
   logic [sgb_pkg::RADIUS_W-1:0]  radius_ff, radius_in;
   logic [sgb_pkg::WEIGHTS_W-1:0] weights_ff, weights_in;
   logic [sgb_pkg::DIM_W-1:0]     width_ff, width_in;
   logic [sgb_pkg::DIM_W-1:0]     height_ff, height_in;

   logic [RW-1:0]     r_eff;
   logic [CW-1:0]     w_eff;
   logic [HW-1:0]     h_eff;
   logic [AREA_W-1:0] area;
   logic [NW-1:0]     lat;

   // frame position
   logic [XW-1:0]  in_col_ff, in_col_in;
   logic [IRW-1:0] in_row_ff, in_row_in;
   logic [SW-1:0]  in_slot_ff, in_slot_in;
   logic [WIW-1:0] win_wr_ff, win_wr_in;
   logic [NW-1:0]  n_ff, n_in;
   logic [XW-1:0]  ocol_ff, ocol_in;
   logic [YW-1:0]  orow_ff, orow_in;
   logic [SW-1:0]  out_slot_ff, out_slot_in;

   // item job
   logic [XW-1:0]    c_ff;
   logic [WIW-1:0]   cwin_ff;
   logic [SW-1:0]    hslot_ff;
   logic [PIX_W-1:0] pix_ff;
   logic             emit_ff;
   logic             has_h_ff;
   logic [XW-1:0]    hx_ff, hx_in;
   logic [XW-1:0]    hx_end_ff;

   // tap walk
   logic signed [KW-1:0]  k_ff, k_in;
   logic signed [CXW-1:0] cx_ff, cx_in;
   logic signed [RYW-1:0] ry_ff, ry_in;
   logic [WIW-1:0]        tidx_ff, tidx_in;
   logic [SW-1:0]         vslot_ff, vslot_in;
   logic                  vin_ff;
   logic [CH_W-1:0]       vwt_ff;
   logic                  vlast_ff;
   logic [CH_N-1:0][SUM_W-1:0] sum_ff, sum_in;

   logic [PIX_W-1:0] win_ff [WIN_LEN];
   logic [PIX_W-1:0] line_mem [MEM_DEPTH];
   logic [PIX_W-1:0] rd_ff;

   logic [CH_N-1:0][CH_W-1:0] quot;
   logic                      div_done;

   logic pixel_slot, drop, row_last, col_last, frame_last;
   logic [RW-1:0]     kabs;
   logic [CH_W-1:0]   kwt;
   logic [PIX_W-1:0]  tap_px;
   logic              cx_ok;
   logic [WIW-1:0]    dd;
   logic [WIW:0]      wrap_sum;
   logic [SW:0]       slot_sum;
   logic              mem_we;
   logic [MAW-1:0]    mem_wa, mem_ra;
   logic [PIX_W-1:0]  mem_wd;
   logic              rd_en;
   logic              frame_zero;
   logic [PIX_W-1:0]  quot_word;

   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_pixel_ff;
   logic [sgb_pkg::OUT_POS_W-1:0] rsp_column_ff, rsp_row_ff;
   logic             rsp_end_ff;

   // effective configuration
   always_comb begin
      r_eff = (32'(radius_ff) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_ff);
      if (width_ff == '0) w_eff = CW'(1);
      else if (32'(width_ff) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
      else w_eff = CW'(width_ff);
      if (height_ff == '0) h_eff = HW'(1);
      else if (32'(height_ff) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
      else h_eff = HW'(height_ff);
      area = AREA_W'(sgb_pkg::weight_of(weights_ff, 3'd0));
      for (int d = 1; d <= MAX_RADIUS; d++) begin
         if (d <= 32'(r_eff))
            area = area + (AREA_W'(sgb_pkg::weight_of(weights_ff, 3'(d))) << 1);
      end
      lat = NW'(r_eff) * NW'(w_eff) + NW'(r_eff);
   end

   assign pixel_slot = 32'(in_row_ff) < 32'(h_eff);
   assign drop       = pixel_slot && (req_func == sgb_pkg::FUNC_DRAIN);
   assign row_last   = CW'(in_col_ff) == w_eff - CW'(1);
   assign col_last   = CW'(ocol_ff) == w_eff - CW'(1);
   assign frame_last = col_last && (HW'(orow_ff) == h_eff - HW'(1));
   assign frame_zero = csr_we || (cmd.emit && frame_last);

   // configuration registers
   always_comb begin
      radius_in  = radius_ff;
      weights_in = weights_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      if (csr_we) begin
         unique case (sgb_pkg::csr_index_type'(csr_index))
            sgb_pkg::CSR_RADIUS:  radius_in  = csr_data[sgb_pkg::RADIUS_W-1:0];
            sgb_pkg::CSR_WEIGHTS: weights_in = csr_data;
            sgb_pkg::CSR_WIDTH:   width_in   = csr_data[sgb_pkg::DIM_W-1:0];
            sgb_pkg::CSR_HEIGHT:  height_in  = csr_data[sgb_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // frame counters
   always_comb begin
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_slot_in  = in_slot_ff;
      win_wr_in   = win_wr_ff;
      n_in        = n_ff;
      ocol_in     = ocol_ff;
      orow_in     = orow_ff;
      out_slot_in = out_slot_ff;
      if (frame_zero) begin
         in_col_in   = '0;
         in_row_in   = '0;
         in_slot_in  = '0;
         win_wr_in   = '0;
         n_in        = '0;
         ocol_in     = '0;
         orow_in     = '0;
         out_slot_in = '0;
      end else begin
         if (cmd.accept && !drop) begin
            n_in = n_ff + NW'(1);
            if (row_last) begin
               in_col_in  = '0;
               win_wr_in  = '0;
               in_row_in  = in_row_ff + IRW'(1);
               in_slot_in = (32'(in_slot_ff) == LINE_ROWS - 1) ? '0 : in_slot_ff + SW'(1);
            end else begin
               in_col_in = in_col_ff + XW'(1);
               win_wr_in = (32'(win_wr_ff) == WIN_LEN - 1) ? '0 : win_wr_ff + WIW'(1);
            end
         end
         if (cmd.emit) begin
            if (col_last) begin
               ocol_in     = '0;
               orow_in     = orow_ff + YW'(1);
               out_slot_in = (32'(out_slot_ff) == LINE_ROWS - 1) ? '0 : out_slot_ff + SW'(1);
            end else begin
               ocol_in = ocol_ff + XW'(1);
            end
         end
      end
   end

   // tap walk
   always_comb begin
      kabs   = k_ff[KW-1] ? RW'(-k_ff) : RW'(k_ff);
      kwt    = sgb_pkg::weight_of(weights_ff, 3'(kabs));
      tap_px = win_ff[tidx_ff];
      cx_ok  = !cx_ff[CXW-1] && (cx_ff < signed'(CXW'(w_eff)));
      dd       = WIW'(c_ff - hx_ff) + WIW'(r_eff);
      wrap_sum = {1'b0, cwin_ff} + (WIW+1)'(WIN_LEN) - {1'b0, dd};
      slot_sum = {1'b0, out_slot_ff} + (SW+1)'(LINE_ROWS) - (SW+1)'(r_eff);
      k_in     = k_ff;
      cx_in    = cx_ff;
      ry_in    = ry_ff;
      tidx_in  = tidx_ff;
      vslot_in = vslot_ff;
      sum_in   = sum_ff;
      hx_in    = hx_ff;
      if (cmd.accept) begin
         hx_in = (in_col_ff >= XW'(r_eff)) ? in_col_ff - XW'(r_eff) : '0;
      end
      if (cmd.h_setup) begin
         k_in    = -signed'(KW'(r_eff));
         cx_in   = signed'(CXW'(hx_ff)) - signed'(CXW'(r_eff));
         tidx_in = (cwin_ff >= dd) ? cwin_ff - dd : wrap_sum[WIW-1:0];
         sum_in  = '0;
      end
      if (cmd.h_tap) begin
         for (int ch = 0; ch < CH_N; ch++) begin
            if (cx_ok)
               sum_in[ch] = sum_ff[ch] + SUM_W'(PROD_W'(tap_px[ch*CH_W +: CH_W])
                                                * PROD_W'(kwt));
         end
         k_in    = k_ff + KW'(1);
         cx_in   = cx_ff + CXW'(1);
         tidx_in = (32'(tidx_ff) == WIN_LEN - 1) ? '0 : tidx_ff + WIW'(1);
      end
      if (cmd.h_write) begin
         hx_in = hx_ff + XW'(1);
      end
      if (cmd.v_setup) begin
         k_in     = -signed'(KW'(r_eff));
         ry_in    = signed'(RYW'(orow_ff)) - signed'(RYW'(r_eff));
         vslot_in = (out_slot_ff >= SW'(r_eff)) ? out_slot_ff - SW'(r_eff)
                                                 : slot_sum[SW-1:0];
         sum_in   = '0;
      end
      if (cmd.v_addr) begin
         k_in     = k_ff + KW'(1);
         ry_in    = ry_ff + RYW'(1);
         vslot_in = (32'(vslot_ff) == LINE_ROWS - 1) ? '0 : vslot_ff + SW'(1);
      end
      if (cmd.v_acc) begin
         for (int ch = 0; ch < CH_N; ch++) begin
            if (vin_ff)
               sum_in[ch] = sum_ff[ch] + SUM_W'(PROD_W'(rd_ff[ch*CH_W +: CH_W])
                                                * PROD_W'(vwt_ff));
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < CH_N; ch++) quot_word[ch*CH_W +: CH_W] = quot[ch];
      mem_we = cmd.h_write || cmd.h_raw;
      mem_wa = cmd.h_raw ? {hslot_ff, c_ff} : {hslot_ff, hx_ff};
      mem_wd = cmd.h_raw ? pix_ff : quot_word;
      rd_en  = cmd.v_addr || cmd.v_raw_addr;
      mem_ra = cmd.v_raw_addr ? {out_slot_ff, ocol_ff} : {vslot_ff, ocol_ff};
   end

   sgb_div #(
      .SUM_W  (SUM_W),
      .AREA_W (AREA_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .sums  (sum_ff),
      .area  (area),
      .done  (div_done),
      .quot  (quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= sgb_pkg::RADIUS_RESET;
         weights_ff   <= '0;
         width_ff     <= sgb_pkg::WIDTH_RESET;
         height_ff    <= sgb_pkg::HEIGHT_RESET;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_slot_ff   <= '0;
         win_wr_ff    <= '0;
         n_ff         <= '0;
         ocol_ff      <= '0;
         orow_ff      <= '0;
         out_slot_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         emit_ff      <= 1'b0;
         has_h_ff     <= 1'b0;
      end else begin
         radius_ff   <= radius_in;
         weights_ff  <= weights_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_slot_ff  <= in_slot_in;
         win_wr_ff   <= win_wr_in;
         n_ff        <= n_in;
         ocol_ff     <= ocol_in;
         orow_ff     <= orow_in;
         out_slot_ff <= out_slot_in;
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (cmd.accept) begin
            emit_ff  <= n_ff >= lat;
            has_h_ff <= pixel_slot && (in_col_ff >= XW'(r_eff) || row_last);
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      cx_ff    <= cx_in;
      ry_ff    <= ry_in;
      tidx_ff  <= tidx_in;
      vslot_ff <= vslot_in;
      sum_ff   <= sum_in;
      hx_ff    <= hx_in;
      if (cmd.accept) begin
         c_ff      <= in_col_ff;
         cwin_ff   <= win_wr_ff;
         hslot_ff  <= in_slot_ff;
         pix_ff    <= req_pixel;
         hx_end_ff <= row_last ? XW'(w_eff - CW'(1)) : in_col_ff - XW'(r_eff);
         if (pixel_slot) win_ff[win_wr_ff] <= req_pixel;
      end
      if (cmd.v_addr) begin
         vin_ff   <= !ry_ff[RYW-1] && (ry_ff < signed'(RYW'(h_eff)));
         vwt_ff   <= kwt;
         vlast_ff <= k_ff == signed'(KW'(r_eff));
      end
      if (cmd.emit) begin
         rsp_pixel_ff  <= (r_eff == '0) ? rd_ff : quot_word;
         rsp_column_ff <= sgb_pkg::OUT_POS_W'(ocol_ff);
         rsp_row_ff    <= sgb_pkg::OUT_POS_W'(orow_ff);
         rsp_end_ff    <= frame_last;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) line_mem[mem_wa] <= mem_wd;
      if (rd_en) rd_ff <= line_mem[mem_ra];
   end

   always_comb begin
      status.drop       = drop;
      status.has_h      = has_h_ff;
      status.r_zero     = r_eff == '0;
      status.h_tap_last = k_ff == signed'(KW'(r_eff));
      status.h_last_x   = hx_ff == hx_end_ff;
      status.emit_pend  = emit_ff;
      status.v_last     = vlast_ff;
      status.div_done   = div_done;
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel     = rsp_pixel_ff;
   assign rsp_column    = rsp_column_ff;
   assign rsp_row       = rsp_row_ff;
   assign rsp_frame_end = rsp_end_ff;

endmodule
`default_nettype wire

### hdl/sgb_ctrl.sv
`default_nettype none
module sgb_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire sgb_pkg::status_type  status,
   output sgb_pkg::cmd_type          cmd
);

   sgb_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sgb_pkg::ST_IDLE:
            if (req_valid && !status.drop) state_in = sgb_pkg::ST_DISPATCH;
         sgb_pkg::ST_DISPATCH:
            if (!status.has_h) state_in = sgb_pkg::ST_VCHK;
            else if (status.r_zero) state_in = sgb_pkg::ST_HRAW;
            else state_in = sgb_pkg::ST_HSET;
         sgb_pkg::ST_HSET:   state_in = sgb_pkg::ST_HTAP;
         sgb_pkg::ST_HTAP:
            if (status.h_tap_last) state_in = sgb_pkg::ST_HDIVGO;
         sgb_pkg::ST_HDIVGO: state_in = sgb_pkg::ST_HDIVW;
         sgb_pkg::ST_HDIVW:
            if (status.div_done) state_in = sgb_pkg::ST_HWR;
         sgb_pkg::ST_HWR:
            state_in = status.h_last_x ? sgb_pkg::ST_VCHK : sgb_pkg::ST_HSET;
         sgb_pkg::ST_HRAW:   state_in = sgb_pkg::ST_VCHK;
         sgb_pkg::ST_VCHK:
            if (!status.emit_pend) state_in = sgb_pkg::ST_IDLE;
            else if (status.r_zero) state_in = sgb_pkg::ST_VRAWA;
            else state_in = sgb_pkg::ST_VSET;
         sgb_pkg::ST_VSET:   state_in = sgb_pkg::ST_VADR;
         sgb_pkg::ST_VADR:   state_in = sgb_pkg::ST_VACC;
         sgb_pkg::ST_VACC:
            state_in = status.v_last ? sgb_pkg::ST_VDIVGO : sgb_pkg::ST_VADR;
         sgb_pkg::ST_VDIVGO: state_in = sgb_pkg::ST_VDIVW;
         sgb_pkg::ST_VDIVW:
            if (status.div_done) state_in = sgb_pkg::ST_EMIT;
         sgb_pkg::ST_VRAWA:  state_in = sgb_pkg::ST_VRAWD;
         sgb_pkg::ST_VRAWD:  state_in = sgb_pkg::ST_EMIT;
         sgb_pkg::ST_EMIT:
            if (status.out_free) state_in = sgb_pkg::ST_IDLE;
         default: state_in = sgb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         sgb_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         sgb_pkg::ST_HSET:   cmd.h_setup   = 1'b1;
         sgb_pkg::ST_HTAP:   cmd.h_tap     = 1'b1;
         sgb_pkg::ST_HDIVGO: cmd.div_start = 1'b1;
         sgb_pkg::ST_HWR:    cmd.h_write   = 1'b1;
         sgb_pkg::ST_HRAW:   cmd.h_raw     = 1'b1;
         sgb_pkg::ST_VSET:   cmd.v_setup   = 1'b1;
         sgb_pkg::ST_VADR:   cmd.v_addr    = 1'b1;
         sgb_pkg::ST_VACC:   cmd.v_acc     = 1'b1;
         sgb_pkg::ST_VDIVGO: cmd.div_start = 1'b1;
         sgb_pkg::ST_VRAWA:  cmd.v_raw_addr = 1'b1;
         sgb_pkg::ST_EMIT:   cmd.emit      = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sgb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sgb_pkg::ST_IDLE && req_valid && !status.drop)
      |=> state_ff == sgb_pkg::ST_DISPATCH)
      else $error("accepted item not dispatched");

   a_div_done_waiting: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == sgb_pkg::ST_HDIVW || state_ff == sgb_pkg::ST_VDIVW))
      else $error("divider finished outside a wait state");

   a_acc_after_addr: assert property (@(posedge clock) disable iff (reset)
      state_ff == sgb_pkg::ST_VACC |-> $past(state_ff) == sgb_pkg::ST_VADR)
      else $error("vertical accumulate without a read issued");

   a_emit_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> state_ff == sgb_pkg::ST_IDLE)
      else $error("emit did not end the item");

endmodule
`default_nettype wire

### hdl/separable_gaussian_blur_int.sv
`default_nettype none
// channel  dir  handshake    payload
// req      in   valid/ready  func, pixel_word
// rsp      out  valid/ready  blurred_pixel, out_column, out_row, frame_end
// csr      in   valid/ready  index, data (always ready)
//
// one item at a time; a pixel item runs one horizontal pass per row output it completes
// (none, one, or up to r+1 at row end) and one vertical pass when a pixel is emitted;
// for a nonzero radius each pass waits on the one-bit-per-cycle divider, and the vertical
// pass makes one line store read per tap
// radius zero: items bypass the divider; dropped drain ticks are taken in the idle state
// synchronous reset clears counters and config; the line store is not cleared
// a pending result stalls only the next emit, not the intake of the next item

module separable_gaussian_blur_int #(
   parameter int MAX_RADIUS = sgb_pkg::MAX_RADIUS_DEF,
   parameter int MAX_WIDTH  = sgb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = sgb_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sgb_req_if.sink    req_bus,
   sgb_rsp_if.source  rsp_bus,
   sgb_csr_if.sink    csr_bus
);

   sgb_pkg::cmd_type    cmd;
   sgb_pkg::status_type status;

   assign csr_bus.ready = 1'b1;

   sgb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sgb_datapath #(
      .MAX_RADIUS (MAX_RADIUS),
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_func      (req_bus.func),
      .req_pixel     (req_bus.pixel_word),
      .csr_we        (csr_bus.valid),
      .csr_index     (csr_bus.index),
      .csr_data      (csr_bus.data),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_pixel     (rsp_bus.blurred_pixel),
      .rsp_column    (rsp_bus.out_column),
      .rsp_row       (rsp_bus.out_row),
      .rsp_frame_end (rsp_bus.frame_end),
      .cmd           (cmd),
      .status        (status)
   );

endmodule
`default_nettype wire

### sim/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;

   typedef struct packed {
      logic        func;
      logic [31:0] pixel_word;
   } pixel_item_type;

   typedef struct packed {
      logic [31:0] blurred_pixel;
      logic [9:0]  out_column;
      logic [9:0]  out_row;
      logic        frame_end;
   } blur_out_type;

   logic clock;
   logic reset;

   sgb_req_if req_if ();
   sgb_rsp_if rsp_if ();
   sgb_csr_if csr_if ();

   separable_gaussian_blur_int u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   pixel_item_type pending_pixels [$];
   blur_out_type   expected_pixels [$];
   bit          failed;
   bit          took;
   int          burst_left;
   int          gap_left;
   int          stall_left;
   int          ready_mode;
   int          hold_asks;
   int          hold_done;
   int          hold_left;
   int          pixel_count;

   // blur state
   logic [31:0]  row_win [15];
   logic [31:0]  line_mem [16][1024];
   int unsigned  col_pos;
   int unsigned  row_pos;
   int unsigned  emit_cnt;
   logic [2:0]   cfg_radius;
   logic [63:0]  cfg_weights;
   logic [10:0]  cfg_width;
   logic [10:0]  cfg_height;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic int unsigned eff_width();
      if (cfg_width == 0) return 1;
      return (cfg_width > 1024) ? 1024 : int'(cfg_width);
   endfunction

   function automatic int unsigned eff_height();
      if (cfg_height == 0) return 1;
      return (cfg_height > 1024) ? 1024 : int'(cfg_height);
   endfunction

   function automatic int unsigned tap_weight(input int unsigned d);
      return int'(cfg_weights[8*d +: 8]);
   endfunction

   function automatic int unsigned kernel_area(input int unsigned r);
      int unsigned a;
      a = tap_weight(0);
      for (int unsigned d = 1; d <= r; d++) a += 2 * tap_weight(d);
      return a;
   endfunction

   function automatic logic [31:0] pack_channels(input int unsigned s [4],
                                                 input int unsigned area);
      logic [31:0] v;
      v = '0;
      for (int ch = 0; ch < 4; ch++)
         v[8*ch +: 8] = (area == 0) ? 8'd0 : 8'((s[ch] / area) & 32'hff);
      return v;
   endfunction

   function automatic void row_blur(input int unsigned row, input int unsigned x,
                                    input int unsigned w, input int unsigned r);
      int unsigned s [4];
      int          cx;
      logic [31:0] v;
      if (r == 0) begin
         v = row_win[x % 15];
      end else begin
         s = '{0, 0, 0, 0};
         for (int k = -int'(r); k <= int'(r); k++) begin
            cx = int'(x) + k;
            if (cx < 0 || cx >= int'(w)) continue;
            for (int ch = 0; ch < 4; ch++)
               s[ch] += int'(row_win[cx % 15][8*ch +: 8]) * tap_weight((k < 0) ? -k : k);
         end
         v = pack_channels(s, kernel_area(r));
      end
      line_mem[row % 16][x] = v;
   endfunction

   function automatic logic [31:0] column_blur(input int unsigned row, input int unsigned c,
                                               input int unsigned h, input int unsigned r);
      int unsigned s [4];
      int          ry;
      if (r == 0) return line_mem[row % 16][c];
      s = '{0, 0, 0, 0};
      for (int k = -int'(r); k <= int'(r); k++) begin
         ry = int'(row) + k;
         if (ry < 0 || ry >= int'(h)) continue;
         for (int ch = 0; ch < 4; ch++)
            s[ch] += int'(line_mem[ry % 16][c][8*ch +: 8]) * tap_weight((k < 0) ? -k : k);
      end
      return pack_channels(s, kernel_area(r));
   endfunction

   function automatic void blur_step(input logic f, input logic [31:0] p);
      int unsigned w, h, r, total, n, lat, m;
      blur_out_type o;
      w = eff_width();
      h = eff_height();
      r = cfg_radius;
      total = w * h;
      if (row_pos < h) begin
         if (f == sgb_pkg::FUNC_DRAIN) return;
         row_win[col_pos % 15] = p;
         if (col_pos >= r) row_blur(row_pos, col_pos - r, w, r);
         if (col_pos == w - 1)
            for (int unsigned x = (w > r) ? w - r : 0; x < w; x++) row_blur(row_pos, x, w, r);
      end
      n = row_pos * w + col_pos;
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      lat = r * w + r;
      if (n >= lat && emit_cnt < total) begin
         m = emit_cnt;
         o.blurred_pixel = column_blur(m / w, m % w, h, r);
         o.out_column = 10'(m % w);
         o.out_row = 10'(m / w);
         emit_cnt++;
         o.frame_end = (emit_cnt == total);
         if (o.frame_end) begin
            col_pos = 0;
            row_pos = 0;
            emit_cnt = 0;
         end
         expected_pixels.push_back(o);
      end
   endfunction

   // input side: accept and predict
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         blur_step(req_if.func, req_if.pixel_word);
         void'(pending_pixels.pop_front());
         took <= 1'b1;
      end else begin
         took <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!(req_if.valid && !took)) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_if.valid <= 1'b0;
         end else if (pending_pixels.size() > 0) begin
            req_if.valid <= 1'b1;
            req_if.func <= pending_pixels[0].func;
            req_if.pixel_word <= pending_pixels[0].pixel_word;
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result side
   always @(negedge clock) begin
      if (hold_done < hold_asks) begin
         hold_done = hold_done + 1;
         hold_left = 600;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         if (stall_left <= 0) begin
            stall_left = $urandom_range(16, 128);
            ready_mode = $urandom_range(0, 2);
         end
         stall_left = stall_left - 1;
         case (ready_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= 1'($urandom_range(0, 1));
            default: rsp_if.ready <= (stall_left % 4 == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected item %h", rsp_if.blurred_pixel);
            failed = 1'b1;
         end else begin
            blur_out_type e;
            e = expected_pixels.pop_front();
            if (rsp_if.blurred_pixel !== e.blurred_pixel) begin
               $error("blurred_pixel exp %h got %h", e.blurred_pixel, rsp_if.blurred_pixel);
               failed = 1'b1;
            end
            if (rsp_if.out_column !== e.out_column) begin
               $error("out_column exp %0d got %0d", e.out_column, rsp_if.out_column);
               failed = 1'b1;
            end
            if (rsp_if.out_row !== e.out_row) begin
               $error("out_row exp %0d got %0d", e.out_row, rsp_if.out_row);
               failed = 1'b1;
            end
            if (rsp_if.frame_end !== e.frame_end) begin
               $error("frame_end exp %0d got %0d", e.frame_end, rsp_if.frame_end);
               failed = 1'b1;
            end
         end
      end
   end

   task automatic csr_write(input sgb_pkg::csr_index_type idx, input logic [63:0] d);
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.index = idx;
      csr_if.data = d;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (idx)
         sgb_pkg::CSR_RADIUS:  cfg_radius = d[2:0];
         sgb_pkg::CSR_WEIGHTS: cfg_weights = d;
         sgb_pkg::CSR_WIDTH:   cfg_width = d[10:0];
         default:              cfg_height = d[10:0];
      endcase
      col_pos = 0;
      row_pos = 0;
      emit_cnt = 0;
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (pending_pixels.size() != 0 || req_if.valid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_pixel();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hffffffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic blur_frame(input logic [10:0] w_raw, input logic [10:0] h_raw,
                             input logic [2:0] r, input logic [63:0] wt,
                             input bit pressure);
      int unsigned w, h, lat;
      pixel_item_type it;
      wait_idle();
      csr_write(sgb_pkg::CSR_RADIUS, {61'($urandom), r});
      csr_write(sgb_pkg::CSR_WEIGHTS, wt);
      csr_write(sgb_pkg::CSR_WIDTH, {53'($urandom), w_raw});
      csr_write(sgb_pkg::CSR_HEIGHT, {53'($urandom), h_raw});
      w = eff_width();
      h = eff_height();
      lat = r * w + r;
      for (int unsigned i = 0; i < w * h; i++) begin
         if ($urandom_range(0, 15) == 0) begin
            it.func = sgb_pkg::FUNC_DRAIN;
            it.pixel_word = $urandom;
            pending_pixels.push_back(it);
            pixel_count++;
         end
         it.func = sgb_pkg::FUNC_PIXEL;
         it.pixel_word = pick_pixel();
         pending_pixels.push_back(it);
         pixel_count++;
      end
      for (int unsigned i = 0; i < lat; i++) begin
         it.func = 1'($urandom_range(0, 1));
         it.pixel_word = $urandom;
         pending_pixels.push_back(it);
         pixel_count++;
      end
      if (pressure) hold_asks = hold_asks + 1;
   endtask

   initial begin
      logic [63:0] wt;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.func = sgb_pkg::FUNC_PIXEL;
      req_if.pixel_word = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = sgb_pkg::CSR_RADIUS;
      csr_if.data = '0;
      failed = 1'b0;
      burst_left = 0;
      gap_left = 0;
      stall_left = 0;
      ready_mode = 0;
      hold_asks = 0;
      hold_done = 0;
      hold_left = 0;
      pixel_count = 0;
      took = 1'b0;
      for (int i = 0; i < 15; i++) row_win[i] = '0;
      col_pos = 0;
      row_pos = 0;
      emit_cnt = 0;
      cfg_radius = sgb_pkg::RADIUS_RESET;
      cfg_weights = '0;
      cfg_width = sgb_pkg::WIDTH_RESET;
      cfg_height = sgb_pkg::HEIGHT_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed
      blur_frame(11'd4, 11'd3, 3'd0, 64'h0, 0);
      blur_frame(11'd5, 11'd4, 3'd1, 64'h0, 0);
      blur_frame(11'd6, 11'd5, 3'd2, 64'hffffffffffffffff, 0);
      blur_frame(11'd3, 11'd2, 3'd7, 64'h0102030405060708, 0);
      blur_frame(11'd9, 11'd9, 3'd7, 64'hff00ff00ff00ff01, 0);
      blur_frame(11'd0, 11'd0, 3'd3, 64'h0000000000000001, 0);
      blur_frame(11'd1, 11'd7, 3'd1, 64'h0000000000000402, 0);
      blur_frame(11'd2047, 11'd1, 3'd0, 64'h0, 0);
      blur_frame(11'd12, 11'd10, 3'd1, 64'h0000000000000102, 1);

      // random
      while (pixel_count < 1600) begin
         case ($urandom_range(0, 4))
            0: wt = 64'h0;
            1: wt = 64'hffffffffffffffff;
            2: wt = {$urandom, $urandom} & 64'h0f0f0f0f0f0f0f0f;
            default: wt = {$urandom, $urandom};
         endcase
         blur_frame(11'($urandom_range(1, 12)), 11'($urandom_range(1, 10)),
                    3'($urandom_range(0, 7)), wt, 0);
      end
      wait_idle();
      if (!failed && expected_pixels.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
`default_nettype wire

### filelist.f
hdl/sgb_pkg.sv
hdl/sgb_if.sv
hdl/sgb_div.sv
hdl/sgb_datapath.sv
hdl/sgb_ctrl.sv
hdl/separable_gaussian_blur_int.sv
sim/tb.sv
